// ===== rtl/core/met_pkg.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Shared constants, register and outcome codes, and the multiplier handshake
// structures.
// ----------------------------------------------------------------------------
package met_pkg;

    localparam int COORD_WIDTH_DEF   = 64;
    localparam int FRACTION_BITS_DEF = 45;
    localparam int COUNT_WIDTH_DEF   = 20;

    localparam int POINT_W    = 64;
    localparam int ITER_W     = 20;
    localparam int OUTCOME_W  = 2;
    localparam int RESULT_W   = 24;

    localparam int ESCAPE_LOG2      = 16;
    localparam int ITER_LIMIT_RESET = 1000;

    localparam int INTERVAL_W   = 32;
    localparam int SAVE_COUNT_W = 4;
    localparam logic [INTERVAL_W-1:0]   FIRST_INTERVAL     = 32'd3;
    localparam logic [SAVE_COUNT_W-1:0] SAVES_PER_DOUBLING = 4'd10;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    typedef enum logic {
        REG_ITER_LIMIT = 1'b0,
        REG_LOOP_OFF   = 1'b1
    } met_reg_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OUTCOME_ESCAPED = 2'd0,
        OUTCOME_LIMIT   = 2'd1,
        OUTCOME_LOOP    = 2'd2
    } met_outcome_t;

    typedef struct packed {
        logic start;
        logic half_shift;
    } met_mul_req_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } met_mul_rsp_t;

endpackage

// ===== rtl/core/met_mul_unit.sv =====
// ----------------------------------------------------------------------------
// Fixed-point multiplier for the escape-time unit
// Forms the exact product of two signed coordinates from four partial
// products of one half-width multiplier, truncates the magnitude to the
// fraction bits (one fewer on half_shift) and saturates to the coord range.
// ----------------------------------------------------------------------------
module met_mul_unit #(
    parameter int COORD_WIDTH   = met_pkg::COORD_WIDTH_DEF,
    parameter int FRACTION_BITS = met_pkg::FRACTION_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  met_pkg::met_mul_req_t         req,
    input  logic signed [COORD_WIDTH-1:0] op_a,
    input  logic signed [COORD_WIDTH-1:0] op_b,
    output met_pkg::met_mul_rsp_t         rsp,
    output logic signed [COORD_WIDTH-1:0] product
);
    import met_pkg::*;

    localparam int HALF_W = (COORD_WIDTH + 1) / 2;
    localparam int MAG_W  = 2 * HALF_W;
    localparam int ACC_W  = 4 * HALF_W;
    localparam logic [2:0] LAST_STEP = 3'd4;
    localparam logic [COORD_WIDTH-1:0] MAX_MAG = {1'b0, {(COORD_WIDTH-1){1'b1}}};

    typedef enum logic [1:0] {
        M_IDLE,
        M_MUL,
        M_FIN
    } mul_state_t;

    mul_state_t                    state_reg;
    logic [MAG_W-1:0]              mag_a_reg;
    logic [MAG_W-1:0]              mag_b_reg;
    logic                          neg_reg;
    logic                          half_shift_reg;
    logic [2:0]                    cnt_reg;
    logic [1:0]                    pos_reg;
    logic [MAG_W-1:0]              pp_reg;
    logic [ACC_W-1:0]              acc_reg;
    logic                          done_reg;
    logic                          ovf_reg;
    logic signed [COORD_WIDTH-1:0] product_reg;

    logic [COORD_WIDTH-1:0]        mag_a;
    logic [COORD_WIDTH-1:0]        mag_b;
    logic [HALF_W-1:0]             digit_a;
    logic [HALF_W-1:0]             digit_b;
    logic [ACC_W-1:0]              pp_ext;
    logic [ACC_W-1:0]              pp_shifted;
    logic [ACC_W-1:0]              shifted;
    logic [COORD_WIDTH-1:0]        limit;
    logic [COORD_WIDTH-1:0]        low_part;
    logic                          over;
    logic signed [COORD_WIDTH-1:0] final_value;

    always_comb
    begin
        mag_a   = op_a[COORD_WIDTH-1] ? -op_a : op_a;
        mag_b   = op_b[COORD_WIDTH-1] ? -op_b : op_b;
        digit_a = cnt_reg[1] ? mag_a_reg[MAG_W-1:HALF_W] : mag_a_reg[HALF_W-1:0];
        digit_b = cnt_reg[0] ? mag_b_reg[MAG_W-1:HALF_W] : mag_b_reg[HALF_W-1:0];
        pp_ext  = ACC_W'(pp_reg);
        unique case (pos_reg)
            2'd0:    pp_shifted = pp_ext;
            2'd1:    pp_shifted = pp_ext << HALF_W;
            2'd2:    pp_shifted = pp_ext << MAG_W;
            default: pp_shifted = '0;
        endcase

        shifted  = half_shift_reg ? (acc_reg >> (FRACTION_BITS - 1))
                                  : (acc_reg >> FRACTION_BITS);
        limit    = MAX_MAG + COORD_WIDTH'(neg_reg);
        low_part = shifted[COORD_WIDTH-1:0];
        over     = (|shifted[ACC_W-1:COORD_WIDTH]) || (low_part > limit);
        if (over)
        begin
            final_value = neg_reg ? ~MAX_MAG : MAX_MAG;
        end
        else
        begin
            final_value = neg_reg ? -low_part : low_part;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= M_IDLE;
            mag_a_reg      <= '0;
            mag_b_reg      <= '0;
            neg_reg        <= 1'b0;
            half_shift_reg <= 1'b0;
            cnt_reg        <= '0;
            pos_reg        <= '0;
            pp_reg         <= '0;
            acc_reg        <= '0;
            done_reg       <= 1'b0;
            ovf_reg        <= 1'b0;
            product_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                M_IDLE:
                begin
                    if (req.start)
                    begin
                        mag_a_reg      <= MAG_W'(mag_a);
                        mag_b_reg      <= MAG_W'(mag_b);
                        neg_reg        <= op_a[COORD_WIDTH-1] ^ op_b[COORD_WIDTH-1];
                        half_shift_reg <= req.half_shift;
                        acc_reg        <= '0;
                        cnt_reg        <= '0;
                        state_reg      <= M_MUL;
                    end
                end
                M_MUL:
                begin
                    if (cnt_reg != LAST_STEP)
                    begin
                        pp_reg  <= digit_a * digit_b;
                        pos_reg <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                    end
                    if (cnt_reg != 3'd0)
                    begin
                        acc_reg <= acc_reg + pp_shifted;
                    end
                    if (cnt_reg == LAST_STEP)
                    begin
                        state_reg <= M_FIN;
                    end
                    cnt_reg <= cnt_reg + 3'd1;
                end
                M_FIN:
                begin
                    product_reg <= final_value;
                    ovf_reg     <= over;
                    done_reg    <= 1'b1;
                    state_reg   <= M_IDLE;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.ovf  = ovf_reg;
    assign product  = product_reg;

endmodule

// ===== rtl/core/mandelbrot_escape_time_unit.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot escape-time unit with periodicity check
// One point is worked at a time; s_axis_tready is high only while idle.
// Each iteration forms three products on the shared half-width multiplier,
// each from four partial products that are accumulated, then truncated and
// saturated. A result may wait in the output register while the next point
// is taken. Reset (rst_n low, asynchronous) idles the sequencer, clears the
// output word and restores iteration_limit to 1000 with the loop check on.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_unit #(
    parameter int COORD_WIDTH   = met_pkg::COORD_WIDTH_DEF,
    parameter int FRACTION_BITS = met_pkg::FRACTION_BITS_DEF,
    parameter int COUNT_WIDTH   = met_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // Fields from bit 0: point_real (64), point_imag (64).
    input  logic [2*met_pkg::POINT_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // Fields from bit 0: iteration_count (20), outcome (2), zero pad (2).
    output logic [met_pkg::RESULT_W-1:0]     m_axis_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [met_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [met_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [met_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import met_pkg::*;

    localparam int W        = COORD_WIDTH;
    localparam int LIM_W    = (COUNT_WIDTH < ITER_W) ? COUNT_WIDTH : ITER_W;
    localparam int THR_LOG2 = ESCAPE_LOG2 + FRACTION_BITS;
    localparam int MAG2_W   = (W + 1 > THR_LOG2 + 1) ? W + 1 : THR_LOG2 + 1;
    localparam logic [MAG2_W-1:0] THRESHOLD = MAG2_W'(1) << THR_LOG2;
    localparam logic signed [W+1:0] SUM_MAX = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [W+1:0] SUM_MIN = {3'b111, {(W-1){1'b0}}};
    localparam int PAD_W = RESULT_W - ITER_W - OUTCOME_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_CROSS,
        S_START_RE,
        S_SQ_RE,
        S_SQ_IM,
        S_FINISH
    } state_t;

    state_t                    state_reg;
    logic signed [W-1:0]       cr_reg;
    logic signed [W-1:0]       ci_reg;
    logic signed [W-1:0]       orbit_real_reg;
    logic signed [W-1:0]       orbit_imag_reg;
    logic [W-1:0]              real_sq_reg;
    logic [W-1:0]              imag_sq_reg;
    logic signed [W:0]         sq_diff_reg;
    logic signed [W-1:0]       saved_real_reg;
    logic signed [W-1:0]       saved_imag_reg;
    logic [INTERVAL_W-1:0]     interval_reg;
    logic [INTERVAL_W-1:0]     since_save_reg;
    logic [SAVE_COUNT_W-1:0]   saves_reg;
    logic [LIM_W-1:0]          step_reg;
    logic                      ovf_reg;
    met_outcome_t              outcome_reg;
    logic [LIM_W-1:0]          limit_reg;
    logic                      loop_off_reg;
    logic                      out_valid_reg;
    logic [ITER_W-1:0]         out_count_reg;
    met_outcome_t              out_outcome_reg;

    met_mul_req_t              mul_req;
    met_mul_rsp_t              mul_rsp;
    logic signed [W-1:0]       mul_a;
    logic signed [W-1:0]       mul_b;
    logic signed [W-1:0]       mul_product;

    logic                      in_accept;
    logic                      cfg_write;
    logic                      out_load;
    logic [MAG2_W-1:0]         mag2;
    logic                      step_below;
    logic                      escape;
    logic                      go;
    logic signed [W+1:0]       sum_real;
    logic signed [W+1:0]       sum_imag;
    logic                      over_real;
    logic                      over_imag;
    logic signed [W-1:0]       new_real;
    logic signed [W-1:0]       new_imag;
    logic                      ovf_now;
    logic                      check_on;
    logic                      loop_hit;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign out_load  = (state_reg == S_FINISH) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        mag2       = MAG2_W'(real_sq_reg) + MAG2_W'(imag_sq_reg);
        step_below = step_reg < limit_reg;
        escape     = ovf_reg || (mag2 > THRESHOLD);
        go         = step_below && !escape;

        sum_real  = {sq_diff_reg[W], sq_diff_reg} + {{2{cr_reg[W-1]}}, cr_reg};
        sum_imag  = {{2{mul_product[W-1]}}, mul_product} + {{2{ci_reg[W-1]}}, ci_reg};
        over_real = (sum_real > SUM_MAX) || (sum_real < SUM_MIN);
        over_imag = (sum_imag > SUM_MAX) || (sum_imag < SUM_MIN);
        if (over_real)
        begin
            new_real = sum_real[W+1] ? SUM_MIN[W-1:0] : SUM_MAX[W-1:0];
        end
        else
        begin
            new_real = sum_real[W-1:0];
        end
        if (over_imag)
        begin
            new_imag = sum_imag[W+1] ? SUM_MIN[W-1:0] : SUM_MAX[W-1:0];
        end
        else
        begin
            new_imag = sum_imag[W-1:0];
        end

        ovf_now  = ovf_reg || mul_rsp.ovf;
        check_on = !loop_off_reg && !ovf_now;
        loop_hit = check_on && (orbit_real_reg == saved_real_reg)
                            && (orbit_imag_reg == saved_imag_reg);

        mul_req.start      = ((state_reg == S_CHECK) && go)
                          || (state_reg == S_START_RE)
                          || ((state_reg == S_SQ_RE) && mul_rsp.done);
        mul_req.half_shift = (state_reg == S_CHECK);
        mul_a = (state_reg == S_SQ_RE) ? orbit_imag_reg : orbit_real_reg;
        mul_b = (state_reg == S_CHECK) ? orbit_imag_reg : mul_a;
    end

    met_mul_unit #(
        .COORD_WIDTH   (COORD_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .rsp     (mul_rsp),
        .product (mul_product)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cr_reg          <= '0;
            ci_reg          <= '0;
            orbit_real_reg  <= '0;
            orbit_imag_reg  <= '0;
            real_sq_reg     <= '0;
            imag_sq_reg     <= '0;
            sq_diff_reg     <= '0;
            saved_real_reg  <= '0;
            saved_imag_reg  <= '0;
            interval_reg    <= FIRST_INTERVAL;
            since_save_reg  <= '0;
            saves_reg       <= '0;
            step_reg        <= '0;
            ovf_reg         <= 1'b0;
            outcome_reg     <= OUTCOME_LIMIT;
            limit_reg       <= LIM_W'(ITER_LIMIT_RESET);
            loop_off_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_count_reg   <= '0;
            out_outcome_reg <= OUTCOME_ESCAPED;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (met_reg_t'(paddr[2]))
                    REG_ITER_LIMIT: limit_reg    <= LIM_W'(pwdata[ITER_W-1:0]);
                    REG_LOOP_OFF:   loop_off_reg <= pwdata[0];
                    default:        loop_off_reg <= loop_off_reg;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        cr_reg         <= s_axis_tdata[W-1:0];
                        ci_reg         <= s_axis_tdata[POINT_W+W-1:POINT_W];
                        orbit_real_reg <= '0;
                        orbit_imag_reg <= '0;
                        real_sq_reg    <= '0;
                        imag_sq_reg    <= '0;
                        sq_diff_reg    <= '0;
                        saved_real_reg <= '0;
                        saved_imag_reg <= '0;
                        interval_reg   <= FIRST_INTERVAL;
                        since_save_reg <= '0;
                        saves_reg      <= '0;
                        step_reg       <= '0;
                        ovf_reg        <= 1'b0;
                        state_reg      <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (!step_below)
                    begin
                        outcome_reg <= OUTCOME_LIMIT;
                        state_reg   <= S_FINISH;
                    end
                    else if (escape)
                    begin
                        outcome_reg <= OUTCOME_ESCAPED;
                        state_reg   <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_CROSS;
                    end
                end
                S_CROSS:
                begin
                    if (mul_rsp.done)
                    begin
                        orbit_real_reg <= new_real;
                        orbit_imag_reg <= new_imag;
                        ovf_reg        <= ovf_now || over_real || over_imag;
                        state_reg      <= S_START_RE;
                    end
                end
                S_START_RE:
                begin
                    state_reg <= S_SQ_RE;
                end
                S_SQ_RE:
                begin
                    if (mul_rsp.done)
                    begin
                        real_sq_reg <= mul_product;
                        ovf_reg     <= ovf_now;
                        state_reg   <= S_SQ_IM;
                    end
                end
                S_SQ_IM:
                begin
                    if (mul_rsp.done)
                    begin
                        imag_sq_reg <= mul_product;
                        sq_diff_reg <= {1'b0, real_sq_reg} - {1'b0, mul_product};
                        ovf_reg     <= ovf_now;
                        if (loop_hit)
                        begin
                            outcome_reg <= OUTCOME_LOOP;
                            state_reg   <= S_FINISH;
                        end
                        else
                        begin
                            if (check_on)
                            begin
                                if (since_save_reg == interval_reg)
                                begin
                                    since_save_reg <= INTERVAL_W'(1);
                                    if (saves_reg == SAVES_PER_DOUBLING)
                                    begin
                                        saves_reg <= SAVE_COUNT_W'(1);
                                        if (!interval_reg[INTERVAL_W-1])
                                        begin
                                            interval_reg <= interval_reg << 1;
                                        end
                                    end
                                    else
                                    begin
                                        saves_reg <= saves_reg + SAVE_COUNT_W'(1);
                                    end
                                    saved_real_reg <= orbit_real_reg;
                                    saved_imag_reg <= orbit_imag_reg;
                                end
                                else
                                begin
                                    since_save_reg <= since_save_reg + INTERVAL_W'(1);
                                end
                            end
                            step_reg  <= step_reg + LIM_W'(1);
                            state_reg <= S_CHECK;
                        end
                    end
                end
                S_FINISH:
                begin
                    if (out_load)
                    begin
                        out_count_reg   <= ITER_W'(step_reg);
                        out_outcome_reg <= outcome_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (met_reg_t'(paddr[2]))
            REG_ITER_LIMIT: prdata = APB_DATA_W'(limit_reg);
            REG_LOOP_OFF:   prdata = APB_DATA_W'(loop_off_reg);
            default:        prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_outcome_reg, out_count_reg};

    // An idle sequencer never leaves a multiplier result unconsumed.
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !mul_rsp.done)
        else $error("multiplier result pending while idle");

    // The save counter never runs past the save interval.
    a_since_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        since_save_reg <= interval_reg)
        else $error("save counter passed the save interval");

    // While a point is worked, the iteration count holds or advances by one.
    a_step_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=>
            (step_reg == $past(step_reg)) || (step_reg == $past(step_reg) + LIM_W'(1)))
        else $error("iteration count jumped");

endmodule
